>>> src/frx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared types, register map and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

  // Largest payload a frame may carry, by default.
  localparam int unsigned FRX_MAX_PAYLOAD = 32;

  // Reset values of the start byte registers.
  localparam logic [7:0] FRX_FIRST_START_RST  = 8'd188;
  localparam logic [7:0] FRX_SECOND_START_RST = 8'd207;

  // Register map: the register index is the word address.
  localparam int unsigned FRX_PADDR_W = 3;
  localparam logic REG_FIRST_START  = 1'b0;
  localparam logic REG_SECOND_START = 1'b1;

  // Input item commands.
  localparam logic CMD_RX_BYTE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } frx_in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] frame_type;
    logic [5:0] frame_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
  } frx_out_t;

  // Address width for a store of the given depth (at least one bit).
  function automatic int unsigned frx_addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width that holds every length from zero up to the given maximum.
  function automatic int unsigned frx_len_w(int unsigned max_len);
    return $clog2(max_len + 1);
  endfunction

endpackage

>>> src/frx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is issued.
// ----------------------------------------------------------------------------
module frx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/frx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Two-entry queue that carries accepted frame headers from the front end to
// the readout engine.
// ----------------------------------------------------------------------------
module frx_queue #(
  parameter int unsigned W = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] entry_q [2];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   cnt_q, cnt_d;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

endmodule

>>> src/frx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver front end
// Accepts input transactions, tracks the frame phase and the two running
// checksums, writes payload bytes to the store and queues accepted frames.
// ----------------------------------------------------------------------------
module frx_front #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::FRX_MAX_PAYLOAD,
  localparam int unsigned AW    = frx_pkg::frx_addr_w(MAX_PAYLOAD),
  localparam int unsigned LEN_W = frx_pkg::frx_len_w(MAX_PAYLOAD)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  frx_pkg::frx_in_t  in_data_i,
  input  logic [7:0]        first_start_i,
  input  logic [7:0]        second_start_i,
  input  logic              back_busy_i,
  input  logic              queue_full_i,
  output logic              queue_push_o,
  output logic [7:0]        queue_type_o,
  output logic [LEN_W-1:0]  queue_len_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [7:0]        ram_wdata_o
);

  import frx_pkg::*;

  typedef enum logic [6:0] {
    PH_START1 = 7'b0000001,
    PH_START2 = 7'b0000010,
    PH_TYPE   = 7'b0000100,
    PH_LEN    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CHK1   = 7'b0100000,
    PH_CHK2   = 7'b1000000
  } frx_phase_e;

  localparam logic [7:0] MaxLenByte = 8'(MAX_PAYLOAD);

  frx_phase_e       phase_q, phase_d;
  logic [7:0]       sum1_q, sum1_d;
  logic [7:0]       sum2_q, sum2_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [7:0]       type_q, type_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             pending_q, pending_d;

  logic             accept;
  logic [7:0]       rx;
  logic [7:0]       sum1_acc;
  logic [LEN_W-1:0] count_inc;

  // Hold off while a payload byte would overwrite the store during readout,
  // or while the final check byte finds the queue full.
  assign in_stall_o = ((phase_q == PH_DATA) && back_busy_i) ||
                      ((phase_q == PH_CHK2) && queue_full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign rx         = in_data_i.rx_byte;
  assign sum1_acc   = sum1_q + rx;
  assign count_inc  = count_q + LEN_W'(1);

  // Frame phase and checksum tracking.
  always_comb begin
    phase_d      = phase_q;
    sum1_d       = sum1_q;
    sum2_d       = sum2_q;
    count_d      = count_q;
    type_d       = type_q;
    len_d        = len_q;
    pending_d    = pending_q;
    queue_push_o = 1'b0;
    ram_we_o     = 1'b0;
    if (accept) begin
      if (in_data_i.command == CMD_RELEASE) begin
        pending_d = 1'b0;
      end else if (!pending_q) begin
        unique case (phase_q)
          PH_START2: begin
            phase_d = (rx == second_start_i) ? PH_TYPE : PH_START1;
          end
          PH_TYPE: begin
            type_d  = rx;
            sum1_d  = rx;
            sum2_d  = rx;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (rx <= MaxLenByte) begin
              len_d   = LEN_W'(rx);
              sum1_d  = sum1_acc;
              sum2_d  = sum2_q + sum1_acc;
              count_d = '0;
              phase_d = (rx == 8'd0) ? PH_CHK1 : PH_DATA;
            end else begin
              phase_d = PH_START1;
            end
          end
          PH_DATA: begin
            ram_we_o = 1'b1;
            sum1_d   = sum1_acc;
            sum2_d   = sum2_q + sum1_acc;
            count_d  = count_inc;
            if (count_inc >= len_q) begin
              phase_d = PH_CHK1;
            end
          end
          PH_CHK1: begin
            phase_d = (rx == sum1_q) ? PH_CHK2 : PH_START1;
          end
          PH_CHK2: begin
            phase_d = PH_START1;
            if (rx == sum2_q) begin
              pending_d    = 1'b1;
              queue_push_o = 1'b1;
            end
          end
          default: begin
            phase_d = (rx == first_start_i) ? PH_START2 : PH_START1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START1;
      sum1_q    <= 8'd0;
      sum2_q    <= 8'd0;
      count_q   <= '0;
      type_q    <= 8'd0;
      len_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      sum1_q    <= sum1_d;
      sum2_q    <= sum2_d;
      count_q   <= count_d;
      type_q    <= type_d;
      len_q     <= len_d;
      pending_q <= pending_d;
    end
  end

  // The count never reaches the store depth while in the payload phase.
  assign ram_waddr_o  = count_q[AW-1:0];
  assign ram_wdata_o  = rx;
  assign queue_type_o = type_q;
  assign queue_len_o  = len_q;

endmodule

>>> src/frx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver readout engine
// Takes frame descriptors from the queue and reads the payload store out as
// one result transaction per byte, with the read data as output register.
// ----------------------------------------------------------------------------
module frx_back #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::FRX_MAX_PAYLOAD,
  localparam int unsigned AW    = frx_pkg::frx_addr_w(MAX_PAYLOAD),
  localparam int unsigned LEN_W = frx_pkg::frx_len_w(MAX_PAYLOAD)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              queue_valid_i,
  input  logic [7:0]        queue_type_i,
  input  logic [LEN_W-1:0]  queue_len_i,
  output logic              queue_pop_o,
  output logic              busy_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output frx_pkg::frx_out_t out_data_o
);

  import frx_pkg::*;

  logic             active_q, active_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [7:0]       type_q, type_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic             ovalid_q, ovalid_d;
  logic [7:0]       otype_q, otype_d;
  logic [5:0]       olen_q, olen_d;
  logic [4:0]       oidx_q, oidx_d;
  logic             obv_q, obv_d;
  logic             olast_q, olast_d;

  logic             slot_free;
  logic             is_last;

  assign slot_free = !ovalid_q || !out_stall_i;
  assign is_last   = (len_q == '0) || ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

  // Readout sequencing: fetch a descriptor, then one result per free slot.
  always_comb begin
    active_d    = active_q;
    idx_d       = idx_q;
    type_d      = type_q;
    len_d       = len_q;
    ovalid_d    = ovalid_q;
    otype_d     = otype_q;
    olen_d      = olen_q;
    oidx_d      = oidx_q;
    obv_d       = obv_q;
    olast_d     = olast_q;
    queue_pop_o = 1'b0;
    ram_re_o    = 1'b0;
    if (slot_free) begin
      ovalid_d = 1'b0;
    end
    if (active_q && slot_free) begin
      ovalid_d = 1'b1;
      otype_d  = type_q;
      olen_d   = 6'(len_q);
      oidx_d   = 5'(idx_q);
      obv_d    = (len_q != '0);
      olast_d  = is_last;
      ram_re_o = (len_q != '0);
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end
    if (!active_q && queue_valid_i) begin
      queue_pop_o = 1'b1;
      active_d    = 1'b1;
      idx_d       = '0;
      type_d      = queue_type_i;
      len_d       = queue_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Descriptor and sideband registers carry no reset.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    type_q  <= type_d;
    len_q   <= len_d;
    otype_q <= otype_d;
    olen_q  <= olen_d;
    oidx_q  <= oidx_d;
    obv_q   <= obv_d;
    olast_q <= olast_d;
  end

  assign busy_o      = active_q || queue_valid_i;
  assign ram_raddr_o = idx_q;
  assign out_valid_o = ovalid_q;

  // An empty frame shows a zero data byte.
  always_comb begin
    out_data_o.frame_type   = otype_q;
    out_data_o.frame_length = olen_q;
    out_data_o.byte_index   = oidx_q;
    out_data_o.payload_byte = obv_q ? ram_rdata_i : 8'd0;
    out_data_o.byte_valid   = obv_q;
    out_data_o.last         = olast_q;
  end

endmodule

>>> src/framed_packet_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver core
// Serial byte deframer with two 8-bit running checksums and payload readout.
// ----------------------------------------------------------------------------
// The core takes one input transaction per cycle: a received byte or a release
// command. Frames are two start bytes, a type byte, a length byte (at most
// MAX_PAYLOAD), the payload and two check bytes. A frame that passes both
// checks is read out as one result transaction per payload byte (one result
// with no data for an empty frame), with last set on the final one; the core
// then ignores received bytes until a release command arrives. Readout first
// fetches the frame descriptor and then issues the results through the payload
// store read port, a new one whenever the output is not stalled. A payload byte
// of a new frame is held off while an earlier frame is still queued or being
// read out, and the final check byte is held off while the two-entry descriptor
// queue is full; all other input transactions are taken every cycle.
module framed_packet_receiver_core #(
  parameter int unsigned MAX_PAYLOAD = frx_pkg::FRX_MAX_PAYLOAD
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  frx_pkg::frx_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output frx_pkg::frx_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frx_pkg::FRX_PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import frx_pkg::*;

  localparam int unsigned AW    = frx_addr_w(MAX_PAYLOAD);
  localparam int unsigned LEN_W = frx_len_w(MAX_PAYLOAD);
  localparam int unsigned DW    = 8 + LEN_W;

  logic [7:0]       first_start_q;
  logic [7:0]       second_start_q;
  logic             cfg_write;
  logic             reg_sel;

  logic             back_busy;
  logic             queue_full;
  logic             queue_push;
  logic             queue_pop;
  logic             queue_valid;
  logic [7:0]       push_type;
  logic [LEN_W-1:0] push_len;
  logic [DW-1:0]    head;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  // Configuration port: word address selects the register.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_start_q  <= FRX_FIRST_START_RST;
      second_start_q <= FRX_SECOND_START_RST;
    end else if (cfg_write) begin
      if (reg_sel == REG_FIRST_START) begin
        first_start_q <= pwdata[7:0];
      end else begin
        second_start_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_FIRST_START) ? {24'd0, first_start_q}
                                               : {24'd0, second_start_q};

  // Front end: phase tracking, checksums and payload capture.
  frx_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .first_start_i  (first_start_q),
    .second_start_i (second_start_q),
    .back_busy_i    (back_busy),
    .queue_full_i   (queue_full),
    .queue_push_o   (queue_push),
    .queue_type_o   (push_type),
    .queue_len_o    (push_len),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata)
  );

  // Descriptor queue between front end and readout.
  frx_queue #(
    .W (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .data_i  ({push_type, push_len}),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (head)
  );

  // Payload store.
  frx_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Readout engine.
  frx_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .queue_type_i  (head[DW-1:LEN_W]),
    .queue_len_i   (head[LEN_W-1:0]),
    .queue_pop_o   (queue_pop),
    .busy_o        (back_busy),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

>>> tb/sv/framed_packet_receiver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet receiver core testbench
// Sends serial bytes and release commands into the deframer, predicts every
// payload readout transaction with a cycle-free model of the frame parser, and
// checks the results in order. Start byte registers are rewritten over APB
// between test phases, while the core is idle.
// ----------------------------------------------------------------------------
module framed_packet_receiver_core_tb;
  import frx_pkg::*;

  localparam int unsigned MAX_LEN        = FRX_MAX_PAYLOAD;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS    = 52;

  // Parser phases of the deframer.
  typedef enum logic [2:0] {
    PH_HUNT_FIRST,
    PH_HUNT_SECOND,
    PH_GET_TYPE,
    PH_GET_LENGTH,
    PH_GET_PAYLOAD,
    PH_GET_SUM_A,
    PH_GET_SUM_B
  } parse_phase_e;

  // Ways to spoil a generated frame.
  typedef enum int {
    FLAW_NONE,
    FLAW_SUM_A,
    FLAW_SUM_B,
    FLAW_SECOND_START
  } frame_flaw_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  frx_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  frx_out_t out_data;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [FRX_PADDR_W-1:0] paddr   = '0;
  logic [31:0]            pwdata  = '0;
  logic [31:0]            prdata;
  logic                   pready;

  framed_packet_receiver_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Stimulus and scoreboard storage.
  frx_in_t  tx_queue[$];
  frx_out_t readout_queue[$];

  // Predicted deframer state and start byte settings.
  parse_phase_e parse_phase    = PH_HUNT_FIRST;
  logic [7:0]   start_first    = FRX_FIRST_START_RST;
  logic [7:0]   start_second   = FRX_SECOND_START_RST;
  logic [7:0]   run_sum        = '0;
  logic [7:0]   sum_of_sums    = '0;
  logic [5:0]   payload_cnt    = '0;
  logic [7:0]   latched_type   = '0;
  logic [5:0]   latched_len    = '0;
  logic [7:0]   payload_mem[MAX_LEN];
  logic         frame_held     = 1'b0;

  // Run bookkeeping.
  int unsigned error_count   = 0;
  int unsigned sent_count    = 0;
  int unsigned result_count  = 0;
  int unsigned frame_count   = 0;
  int unsigned setting_count = 1;
  int unsigned phase_items   = 0;
  int unsigned idle_cycles   = 0;
  bit          sender_calm   = 1'b1;
  bit          receiver_calm = 1'b1;

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Advance the predicted parser by one accepted transaction.
  task automatic parse_transaction(input frx_in_t txn);
    frx_out_t   beat;
    logic [7:0] rx;
    rx = txn.rx_byte;
    if (txn.command == CMD_RELEASE) begin
      frame_held = 1'b0;
      return;
    end
    // Bytes are dropped while a frame waits for release.
    if (frame_held) return;
    case (parse_phase)
      PH_HUNT_SECOND: begin
        parse_phase = (rx == start_second) ? PH_GET_TYPE : PH_HUNT_FIRST;
      end
      PH_GET_TYPE: begin
        latched_type = rx;
        run_sum      = rx;
        sum_of_sums  = rx;
        parse_phase  = PH_GET_LENGTH;
      end
      PH_GET_LENGTH: begin
        if (rx <= MAX_LEN) begin
          latched_len = rx[5:0];
          run_sum     = run_sum + rx;
          sum_of_sums = sum_of_sums + run_sum;
          payload_cnt = '0;
          parse_phase = (rx == 8'd0) ? PH_GET_SUM_A : PH_GET_PAYLOAD;
        end else begin
          parse_phase = PH_HUNT_FIRST;
        end
      end
      PH_GET_PAYLOAD: begin
        payload_mem[payload_cnt[4:0]] = rx;
        run_sum     = run_sum + rx;
        sum_of_sums = sum_of_sums + run_sum;
        payload_cnt = payload_cnt + 6'd1;
        if (payload_cnt >= latched_len) parse_phase = PH_GET_SUM_A;
      end
      PH_GET_SUM_A: begin
        parse_phase = (rx == run_sum) ? PH_GET_SUM_B : PH_HUNT_FIRST;
      end
      PH_GET_SUM_B: begin
        parse_phase = PH_HUNT_FIRST;
        if (rx == sum_of_sums) begin
          // Good frame: one readout per payload byte, or one empty marker.
          frame_held = 1'b1;
          frame_count++;
          beat.frame_type   = latched_type;
          beat.frame_length = latched_len;
          if (latched_len == 6'd0) begin
            beat.byte_index   = '0;
            beat.payload_byte = '0;
            beat.byte_valid   = 1'b0;
            beat.last         = 1'b1;
            readout_queue.push_back(beat);
          end else begin
            for (int k = 0; k < latched_len; k++) begin
              beat.byte_index   = k[4:0];
              beat.payload_byte = payload_mem[k];
              beat.byte_valid   = 1'b1;
              beat.last         = (k + 1 == latched_len);
              readout_queue.push_back(beat);
            end
          end
        end
      end
      default: begin
        parse_phase = (rx == start_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
      end
    endcase
  endtask

  // Input driver: presents queued transactions, with random gaps unless the sender is calm.
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_n) begin
    logic    next_valid;
    frx_in_t next_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_transaction(in_data);
        sent_count++;
      end
      if (!(in_valid && in_stall)) begin
        next_valid = 1'b0;
        next_data  = in_data;
        if (send_gap > 0) begin
          send_gap--;
        end else if (tx_queue.size() > 0) begin
          next_valid = 1'b1;
          next_data  = tx_queue.pop_front();
          send_gap   = sender_calm ? 0 : pick_gap();
        end
        in_valid <= next_valid;
        in_data  <= next_data;
      end
    end
  end

  // Compare one field of a readout transaction.
  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  // Output monitor: checks readout transactions and drives random stalls unless the receiver is calm.
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_n) begin
    frx_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (readout_queue.size() == 0) begin
          $error("readout transaction with nothing expected: %p", out_data);
          error_count++;
        end else begin
          want = readout_queue.pop_front();
          compare_field("frame_type",   want.frame_type,   out_data.frame_type);
          compare_field("frame_length", want.frame_length, out_data.frame_length);
          compare_field("byte_index",   want.byte_index,   out_data.byte_index);
          compare_field("payload_byte", want.payload_byte, out_data.payload_byte);
          compare_field("byte_valid",   want.byte_valid,   out_data.byte_valid);
          compare_field("last",         want.last,         out_data.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!receiver_calm && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // APB write of one start byte register; mirrored into the prediction and
  // read back once the write has landed.
  task automatic write_start_byte(input logic reg_idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FRX_PADDR_W'({reg_idx, 2'b00});
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_FIRST_START) start_first = value;
    else start_second = value;
    @(posedge clk_i);
    if (prdata !== {24'd0, value}) begin
      $error("prdata mismatch: expected %0d, got %0d", value, prdata);
      error_count++;
    end
  endtask

  // Wait until all transactions are sent and all readouts have arrived.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (tx_queue.size() > 0 || in_valid || readout_queue.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_byte(input logic [7:0] value, input bit counted);
    frx_in_t txn;
    txn.command = CMD_RX_BYTE;
    txn.rx_byte = value;
    tx_queue.push_back(txn);
    if (counted) phase_items++;
  endtask

  // A release carries a random byte that the core must disregard.
  task automatic queue_release();
    frx_in_t txn;
    txn.command = CMD_RELEASE;
    txn.rx_byte = 8'($urandom);
    tx_queue.push_back(txn);
    phase_items++;
  endtask

  // Queue a complete frame with correct or spoiled check bytes, or only a spoiled start byte pair.
  task automatic queue_frame(input logic [7:0] ftype, input int unsigned len,
                             input frame_flaw_e flaw);
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] pb;
    queue_byte(start_first, 1'b1);
    if (flaw == FLAW_SECOND_START) begin
      queue_byte(start_second ^ 8'($urandom_range(1, 255)), 1'b1);
      return;
    end
    queue_byte(start_second, 1'b1);
    queue_byte(ftype, 1'b1);
    queue_byte(8'(len), 1'b1);
    sum_a = ftype;
    sum_b = ftype;
    sum_a = sum_a + 8'(len);
    sum_b = sum_b + sum_a;
    for (int unsigned k = 0; k < len; k++) begin
      pb    = 8'($urandom);
      sum_a = sum_a + pb;
      sum_b = sum_b + sum_a;
      queue_byte(pb, 1'b1);
    end
    if (flaw == FLAW_SUM_A) sum_a = sum_a ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_SUM_B) sum_b = sum_b ^ 8'($urandom_range(1, 255));
    queue_byte(sum_a, 1'b1);
    queue_byte(sum_b, 1'b1);
  endtask

  // Frame header with a length above the payload limit.
  task automatic queue_oversized_header(input logic [7:0] len);
    queue_byte(start_first, 1'b1);
    queue_byte(start_second, 1'b1);
    queue_byte(8'($urandom), 1'b1);
    queue_byte(len, 1'b1);
  endtask

  // Payload length: mostly short frames, a few up to the limit.
  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 4);
    if (roll < 85) return $urandom_range(5, 12);
    if (roll < 95) return $urandom_range(13, MAX_LEN - 1);
    return MAX_LEN;
  endfunction

  // One random test phase of well-formed frames mixed with noise.
  task automatic run_random_phase();
    int unsigned roll;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        queue_frame(8'($urandom), pick_length(), FLAW_NONE);
        // Bytes arriving while a frame is held are dropped.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
        end
        queue_release();
      end else if (roll < 78) begin
        queue_frame(8'($urandom), pick_length(),
                    ($urandom_range(0, 1) == 0) ? FLAW_SUM_A : FLAW_SUM_B);
      end else if (roll < 83) begin
        queue_frame(8'($urandom), 0, FLAW_SECOND_START);
      end else if (roll < 88) begin
        queue_oversized_header(8'($urandom_range(MAX_LEN + 1, 255)));
      end else if (roll < 95) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'b1);
      end else begin
        queue_release();
      end
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    foreach (payload_mem[i]) payload_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: empty frame with a dropped byte before release, release
    // while nothing is held, bad second start byte, oversized length and a
    // spoiled second check byte.
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    queue_frame(8'hFF, 0, FLAW_NONE);
    queue_byte(8'h5A, 1'b1);
    queue_release();
    queue_release();
    queue_frame(8'h00, 0, FLAW_SECOND_START);
    queue_oversized_header(8'd33);
    queue_frame(8'h00, 1, FLAW_SUM_B);
    wait_drained();

    // Random phases under different start byte settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_start_byte(REG_FIRST_START, 8'h00);
          write_start_byte(REG_SECOND_START, 8'hFF);
        end
        1: begin
          write_start_byte(REG_FIRST_START, 8'hFF);
          write_start_byte(REG_SECOND_START, 8'h00);
        end
        3: begin
          // Both start bytes equal.
          write_start_byte(REG_FIRST_START, 8'h7E);
          write_start_byte(REG_SECOND_START, 8'h7E);
        end
        4: begin
          write_start_byte(REG_FIRST_START, FRX_FIRST_START_RST);
          write_start_byte(REG_SECOND_START, FRX_SECOND_START_RST);
        end
        default: begin
          write_start_byte(REG_FIRST_START, 8'($urandom));
          write_start_byte(REG_SECOND_START, 8'($urandom));
        end
      endcase
      setting_count++;
      sender_calm   = (ph == 2);
      receiver_calm = (ph == 4);
      run_random_phase();
      // The sender holds off here until every readout has come back.
      wait_drained();
    end

    if (readout_queue.size() != 0) begin
      $error("%0d readout transactions never arrived", readout_queue.size());
      error_count++;
    end
    $display("Sent %0d input transactions under %0d start byte settings.",
             sent_count, setting_count);
    $display("Accepted %0d frames and checked %0d readout transactions.",
             frame_count, result_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
